[rtl/sli_pkg.sv]
// sli_pkg: shared types and constants for the sorted list intersection block
// no dependencies
`timescale 1ns / 1ps

package sli_pkg;

    localparam int SLI_LIST_DEPTH = 64;
    localparam int SLI_VALUE_BITS = 16;
    localparam int SLI_FIELD_W    = 16;
    localparam int SLI_CMD_W      = 2;

    localparam logic [SLI_CMD_W-1:0] CMD_LEFT  = 2'd0;
    localparam logic [SLI_CMD_W-1:0] CMD_RIGHT = 2'd1;
    localparam logic [SLI_CMD_W-1:0] CMD_RUN   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic adv_left;
        logic adv_right;
        logic take_match;
        logic emit_pend;
        logic finish;
    } t_step;

endpackage

[rtl/sli_list_mem.sv]
// sli_list_mem: one list store, single write port, registered read port
// depends on sli_pkg; instanced twice by the top level
`timescale 1ns / 1ps

module sli_list_mem
    import sli_pkg::*;
#(
    parameter int DEPTH = SLI_LIST_DEPTH,
    parameter int WIDTH = SLI_FIELD_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sli_merge_ctrl.sv]
// sli_merge_ctrl: list counts, load path, merge sequencer and result register
// depends on sli_pkg; drives the two sli_list_mem stores
`timescale 1ns / 1ps

module sli_merge_ctrl
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = SLI_LIST_DEPTH,
    parameter int STORE_W    = SLI_FIELD_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [SLI_CMD_W-1:0]          i_command,
    input  logic [STORE_W-1:0]            i_value,
    output logic                          o_we_left,
    output logic                          o_we_right,
    output logic [$clog2(LIST_DEPTH)-1:0] o_waddr,
    output logic [$clog2(LIST_DEPTH)-1:0] o_raddr_left,
    output logic [$clog2(LIST_DEPTH)-1:0] o_raddr_right,
    input  logic [STORE_W-1:0]            i_rdata_left,
    input  logic [STORE_W-1:0]            i_rdata_right,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [STORE_W-1:0]            o_match,
    output logic                          o_has_match,
    output logic                          o_last,
    output logic                          o_ovf
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    t_state r_state, n_state;
    t_step  step;

    logic [CW-1:0]      r_lcnt, r_rcnt, r_li, r_ri;
    logic               r_ovf;
    logic [STORE_W-1:0] r_pend;
    logic               r_pend_v;
    logic               r_out_v;
    logic [STORE_W-1:0] r_out_val;
    logic               r_out_has, r_out_last, r_out_ovf;

    logic accept, slot_free, more, load_left, load_right, start_run;

    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_out_v || !i_stall;
    assign more      = (r_li < r_lcnt) && (r_ri < r_rcnt);

    always_comb begin
        load_left  = 1'b0;
        load_right = 1'b0;
        start_run  = 1'b0;
        unique case (i_command)
            CMD_LEFT:  load_left  = accept;
            CMD_RIGHT: load_right = accept;
            CMD_RUN:   start_run  = accept;
            default: ;
        endcase
    end

    // step decode per state
    always_comb begin
        step = '0;
        unique case (r_state)
            ST_CMP: begin
                if (i_rdata_left > i_rdata_right) begin
                    step.adv_right = 1'b1;
                end else if (i_rdata_left < i_rdata_right) begin
                    step.adv_left = 1'b1;
                end else if (!r_pend_v || slot_free) begin
                    step.adv_left   = 1'b1;
                    step.adv_right  = 1'b1;
                    step.take_match = 1'b1;
                    step.emit_pend  = r_pend_v;
                end
            end
            ST_FINISH: step.finish = slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start_run) n_state = ST_READ;
            ST_READ:   n_state = more ? ST_CMP : ST_FINISH;
            ST_CMP:    if (step.adv_left || step.adv_right) n_state = ST_READ;
            ST_FINISH: if (step.finish) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_lcnt   <= '0;
            r_rcnt   <= '0;
            r_li     <= '0;
            r_ri     <= '0;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_left) begin
                if (r_lcnt < FULL) r_lcnt <= CW'(r_lcnt + 1'b1);
                else r_ovf <= 1'b1;
            end
            if (load_right) begin
                if (r_rcnt < FULL) r_rcnt <= CW'(r_rcnt + 1'b1);
                else r_ovf <= 1'b1;
            end
            if (start_run) begin
                r_li     <= '0;
                r_ri     <= '0;
                r_pend_v <= 1'b0;
            end
            if (step.adv_left)   r_li <= CW'(r_li + 1'b1);
            if (step.adv_right)  r_ri <= CW'(r_ri + 1'b1);
            if (step.take_match) r_pend_v <= 1'b1;
            if (step.finish) begin
                r_lcnt   <= '0;
                r_rcnt   <= '0;
                r_ovf    <= 1'b0;
                r_pend_v <= 1'b0;
            end
            if (step.emit_pend || step.finish) r_out_v <= 1'b1;
            else if (r_out_v && !i_stall) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.take_match) r_pend <= i_rdata_left;
        if (step.emit_pend || step.finish) begin
            r_out_val  <= r_pend_v ? r_pend : '0;
            r_out_has  <= r_pend_v;
            r_out_last <= step.finish;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_we_left     = load_left && (r_lcnt < FULL);
    assign o_we_right    = load_right && (r_rcnt < FULL);
    assign o_waddr       = load_left ? r_lcnt[AW-1:0] : r_rcnt[AW-1:0];
    assign o_raddr_left  = r_li[AW-1:0];
    assign o_raddr_right = r_ri[AW-1:0];
    assign o_valid       = r_out_v;
    assign o_match       = r_out_val;
    assign o_has_match   = r_out_has;
    assign o_last        = r_out_last;
    assign o_ovf         = r_out_ovf;

endmodule

[rtl/sorted_list_intersection.sv]
// sorted_list_intersection: load beats are written into the stores, one load per cycle while idle
// a run alternates registered store reads (ST_READ) and a compare (ST_CMP) per merge step,
// then ST_FINISH; result stalls can hold ST_CMP and ST_FINISH; input stalls meanwhile
// synchronous active-low reset empties both lists and clears the overflow flag
// store contents are not reset; depends on sli_pkg, sli_list_mem, sli_merge_ctrl
`timescale 1ns / 1ps

module sorted_list_intersection
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = SLI_LIST_DEPTH,
    parameter int VALUE_BITS = SLI_VALUE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SLI_CMD_W-1:0]   i_command,
    input  logic [SLI_FIELD_W-1:0] i_item_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SLI_FIELD_W-1:0] o_match_value,
    output logic                   o_has_match,
    output logic                   o_last_result,
    output logic                   o_overflow_seen
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int SW = (VALUE_BITS < SLI_FIELD_W) ? VALUE_BITS : SLI_FIELD_W;

    logic          we_left, we_right;
    logic [AW-1:0] waddr, raddr_left, raddr_right;
    logic [SW-1:0] rdata_left, rdata_right, match;

    sli_merge_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .STORE_W    (SW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_value       (i_item_value[SW-1:0]),
        .o_we_left     (we_left),
        .o_we_right    (we_right),
        .o_waddr       (waddr),
        .o_raddr_left  (raddr_left),
        .o_raddr_right (raddr_right),
        .i_rdata_left  (rdata_left),
        .i_rdata_right (rdata_right),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_match       (match),
        .o_has_match   (o_has_match),
        .o_last        (o_last_result),
        .o_ovf         (o_overflow_seen)
    );

    sli_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(SW)) u_left (
        .i_clk   (i_clk),
        .i_we    (we_left),
        .i_waddr (waddr),
        .i_wdata (i_item_value[SW-1:0]),
        .i_raddr (raddr_left),
        .o_rdata (rdata_left)
    );

    sli_list_mem #(.DEPTH(LIST_DEPTH), .WIDTH(SW)) u_right (
        .i_clk   (i_clk),
        .i_we    (we_right),
        .i_waddr (waddr),
        .i_wdata (i_item_value[SW-1:0]),
        .i_raddr (raddr_right),
        .o_rdata (rdata_right)
    );

    assign o_match_value = SLI_FIELD_W'(match);

endmodule

[rtl/sli_checker.sv]
// sli_checker: port-level assertions for sorted_list_intersection
// depends on sli_pkg; bound to the top level below
`timescale 1ns / 1ps

module sli_checker
    import sli_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [SLI_FIELD_W-1:0] o_match_value,
    input logic                   o_has_match,
    input logic                   o_last_result,
    input logic                   o_overflow_seen
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_match_value) && $stable(o_has_match)
            && $stable(o_last_result) && $stable(o_overflow_seen))
        else $error("stalled result beat changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_match |-> o_last_result && (o_match_value == '0))
        else $error("empty result not final or nonzero");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_match_value, o_has_match, o_last_result,
            o_overflow_seen}))
        else $error("result beat has unknown bits");

    a_run_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_result |-> o_stall)
        else $error("input open while run still has results");

endmodule

bind sorted_list_intersection sli_checker u_sli_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_match_value   (o_match_value),
    .o_has_match     (o_has_match),
    .o_last_result   (o_last_result),
    .o_overflow_seen (o_overflow_seen)
);
